// ===== rtl/core/fixed_point_alu_assert.svh =====
// Assertion macros used by the fixed-point ALU checker.
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define FPA_AST_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fixed_point_alu: check failed");

// Next-cycle implication.
`define FPA_AST_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fixed_point_alu: check failed");

`endif

// ===== rtl/core/fpa_pkg.sv =====
// Shared types and constants of the fixed-point ALU.
package fpa_pkg;

  localparam int DATA_W       = 32;
  localparam int FRAC_BITS_DF = 8;

  localparam logic [3:0] MODE_ADD  = 4'd0;
  localparam logic [3:0] MODE_SUB  = 4'd1;
  localparam logic [3:0] MODE_MUL  = 4'd2;
  localparam logic [3:0] MODE_DIV  = 4'd3;
  localparam logic [3:0] MODE_INC  = 4'd4;
  localparam logic [3:0] MODE_DEC  = 4'd5;
  localparam logic [3:0] MODE_MIN  = 4'd6;
  localparam logic [3:0] MODE_MAX  = 4'd7;
  localparam logic [3:0] MODE_TOI  = 4'd8;
  localparam logic [3:0] MODE_FRI  = 4'd9;

  localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [3:0]               mode;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     divide_by_zero;
    logic                     overflowed;
    logic                     a_equals_b;
    logic                     a_less_than_b;
  } out_t;

endpackage

// ===== rtl/core/fpa_mul.sv =====
// Pipelined fixed-point multiplier: product, magnitude, rounding, saturation.
module fpa_mul
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic signed [DATA_W-1:0] res,
  output logic                     ovf
);

  localparam int PW   = 2 * DATA_W;
  localparam int RQ_W = PW - FRAC_BITS;
  localparam logic [PW-1:0]   HALF   = PW'(1) << (FRAC_BITS - 1);
  localparam logic [RQ_W-1:0] LIM_P  = RQ_W'(32'h7FFF_FFFF);
  localparam logic [RQ_W-1:0] LIM_N  = RQ_W'(33'h1_0000_0000) >> 1;

  logic signed [PW-1:0]     prod_r;
  logic [PW-1:0]            mag_r;
  logic                     neg2_r, neg3_r;
  logic [RQ_W-1:0]          rq_r;
  logic [PW-1:0]            rnd_sum;
  logic signed [DATA_W-1:0] res_nxt;
  logic                     ovf_nxt;
  logic signed [DATA_W-1:0] res_r;
  logic                     ovf_r;

  assign rnd_sum = mag_r + HALF;

  always_comb begin
    ovf_nxt = 1'b0;
    if (neg3_r) begin
      if (rq_r > LIM_N) begin
        ovf_nxt = 1'b1;
        res_nxt = S_MIN;
      end else begin
        res_nxt = -$signed(rq_r[DATA_W-1:0]);
      end
    end else begin
      if (rq_r > LIM_P) begin
        ovf_nxt = 1'b1;
        res_nxt = S_MAX;
      end else begin
        res_nxt = $signed(rq_r[DATA_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
      neg2_r <= prod_r[PW-1];
      mag_r  <= prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);
      neg3_r <= neg2_r;
      rq_r   <= RQ_W'(rnd_sum >> FRAC_BITS);
      res_r  <= res_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign res = res_r;
  assign ovf = ovf_r;

endmodule

// ===== rtl/core/fpa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounded and saturated.
module fpa_div
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic signed [DATA_W-1:0] res,
  output logic                     dbz,
  output logic                     ovf
);

  localparam int NQ = DATA_W + FRAC_BITS;
  localparam logic [NQ:0] LIM_P = (NQ+1)'(32'h7FFF_FFFF);
  localparam logic [NQ:0] LIM_N = (NQ+1)'(33'h0_8000_0000);

  logic [DATA_W-1:0] rem_r [NQ+1];
  logic [NQ-1:0]     num_r [NQ+1];
  logic [NQ-1:0]     q_r   [NQ+1];
  logic [DATA_W-1:0] d_r   [NQ+1];
  logic              neg_r [NQ+1];
  logic              dz_r  [NQ+1];

  logic [DATA_W-1:0] rem_nxt [NQ];
  logic [NQ-1:0]     q_nxt   [NQ];
  logic [DATA_W:0]   trial   [NQ];
  logic              ge      [NQ];

  logic [DATA_W-1:0] na, nb;
  logic              rnd;
  logic [NQ:0]       qf;
  logic signed [DATA_W-1:0] res_nxt, res_r;
  logic              ovf_nxt, ovf_r, dbz_r;

  assign na = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
  assign nb = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);

  always_comb begin
    for (int j = 0; j < NQ; j++) begin
      trial[j]   = {rem_r[j], num_r[j][NQ-1]};
      ge[j]      = trial[j] >= {1'b0, d_r[j]};
      rem_nxt[j] = ge[j] ? DATA_W'(trial[j] - {1'b0, d_r[j]}) : trial[j][DATA_W-1:0];
      q_nxt[j]   = {q_r[j][NQ-2:0], ge[j]};
    end
  end

  // Round half away from zero: bump when twice the remainder reaches the divisor.
  assign rnd = {rem_r[NQ], 1'b0} >= {1'b0, d_r[NQ]};
  assign qf  = {1'b0, q_r[NQ]} + (NQ+1)'(rnd);

  always_comb begin
    ovf_nxt = 1'b0;
    if (dz_r[NQ]) begin
      res_nxt = '0;
    end else if (neg_r[NQ]) begin
      if (qf > LIM_N) begin
        ovf_nxt = 1'b1;
        res_nxt = S_MIN;
      end else begin
        res_nxt = -$signed(qf[DATA_W-1:0]);
      end
    end else begin
      if (qf > LIM_P) begin
        ovf_nxt = 1'b1;
        res_nxt = S_MAX;
      end else begin
        res_nxt = $signed(qf[DATA_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      num_r[0] <= {na, {FRAC_BITS{1'b0}}};
      q_r[0]   <= '0;
      d_r[0]   <= nb;
      neg_r[0] <= a[DATA_W-1] ^ b[DATA_W-1];
      dz_r[0]  <= (b == '0);
      for (int j = 0; j < NQ; j++) begin
        rem_r[j+1] <= rem_nxt[j];
        num_r[j+1] <= num_r[j] << 1;
        q_r[j+1]   <= q_nxt[j];
        d_r[j+1]   <= d_r[j];
        neg_r[j+1] <= neg_r[j];
        dz_r[j+1]  <= dz_r[j];
      end
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
      dbz_r <= dz_r[NQ];
    end
  end

  assign res = res_r;
  assign ovf = ovf_r;
  assign dbz = dbz_r;

endmodule

// ===== rtl/core/fixed_point_alu.sv =====
// Signed Q(32-F).F fixed-point ALU top level: input stage, simple ops, alignment, output.
//
// Usage notes:
// - in_valid/in_ready carry one beat of in_data (mode, operand_a, operand_b);
//   out_valid/out_ready carry one beat of out_data (result plus four flags).
// - Fully pipelined: while in_ready is high a new beat may be accepted every cycle,
//   one result per beat; results leave in the order the beats came in.
// - The divider sets the depth of the pipe: one quotient bit per stage, 32 + FRAC_BITS
//   stages, plus launch and rounding stages.
// - All other operations ride a delay line so every beat sees the same latency.
// - The whole pipe advances together. in_ready is high whenever the output
//   register is empty or being drained, so a stalled receiver freezes every
//   stage in place; nothing is dropped or repeated.
// - Reset (rst_n low, synchronous) clears every valid bit; data registers
//   are not reset.
// - Divide by zero gives 0 with divide_by_zero set. Saturated results set
//   overflowed. Compare flags come with every beat.
module fixed_point_alu
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int NQ  = DATA_W + FRAC_BITS;
  localparam int LAT = NQ + 2;        // divider latency from the input stage
  localparam int MUL_LAT = 4;
  localparam int MD  = LAT - MUL_LAT; // extra delay for multiplier results
  localparam logic signed [DATA_W:0] ONE = (DATA_W+1)'(1) <<< FRAC_BITS;

  typedef struct packed {
    logic [3:0]               mode;
    logic                     eq;
    logic                     lt;
    logic signed [DATA_W-1:0] res;
    logic                     ovf;
  } side_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res;
    logic                     ovf;
  } mres_t;

  logic en;

  // input stage
  logic  s1_valid_r;
  in_t   s1_r;

  // simple ops
  logic signed [DATA_W:0]   ax, yx, sx;
  logic signed [DATA_W-1:0] fri_top;
  side_t                    side_nxt;

  // alignment lines
  logic  side_v_r [LAT];
  side_t side_r   [LAT];
  mres_t mline_r  [MD];

  logic signed [DATA_W-1:0] mul_res, div_res;
  logic                     mul_ovf, div_ovf, div_dbz;

  // output register
  logic out_valid_r;
  out_t out_r, out_nxt;

  // Whole pipe moves when the output slot is free or draining.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= in_data;
    end
  end

  // Add, sub, inc, dec share one 33-bit adder; overflow when the top bits split.
  assign ax      = {s1_r.operand_a[DATA_W-1], s1_r.operand_a};
  assign sx      = ax + yx;
  assign fri_top = s1_r.operand_a >>> (DATA_W - 1 - FRAC_BITS);

  always_comb begin
    case (s1_r.mode)
      MODE_ADD: yx = {s1_r.operand_b[DATA_W-1], s1_r.operand_b};
      MODE_SUB: yx = -{s1_r.operand_b[DATA_W-1], s1_r.operand_b};
      MODE_INC: yx = ONE;
      MODE_DEC: yx = -ONE;
      default:  yx = '0;
    endcase
  end

  always_comb begin
    side_nxt.mode = s1_r.mode;
    side_nxt.eq   = s1_r.operand_a == s1_r.operand_b;
    side_nxt.lt   = s1_r.operand_a < s1_r.operand_b;
    side_nxt.ovf  = 1'b0;
    side_nxt.res  = '0;
    case (s1_r.mode) inside
      MODE_ADD, MODE_SUB, MODE_INC, MODE_DEC: begin
        if (sx[DATA_W] != sx[DATA_W-1]) begin
          side_nxt.ovf = 1'b1;
          side_nxt.res = sx[DATA_W] ? S_MIN : S_MAX;
        end else begin
          side_nxt.res = sx[DATA_W-1:0];
        end
      end
      MODE_MIN: side_nxt.res = side_nxt.lt ? s1_r.operand_a : s1_r.operand_b;
      MODE_MAX: side_nxt.res = (!side_nxt.lt && !side_nxt.eq) ? s1_r.operand_a
                                                              : s1_r.operand_b;
      MODE_TOI: side_nxt.res = s1_r.operand_a >>> FRAC_BITS;
      MODE_FRI: begin
        // fits only when the bits shifted out all match the sign
        if (fri_top == '0 || fri_top == '1) begin
          side_nxt.res = s1_r.operand_a <<< FRAC_BITS;
        end else begin
          side_nxt.ovf = 1'b1;
          side_nxt.res = s1_r.operand_a[DATA_W-1] ? S_MIN : S_MAX;
        end
      end
      default: side_nxt.res = '0;
    endcase
  end

  fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .en  (en),
    .a   (s1_r.operand_a),
    .b   (s1_r.operand_b),
    .res (mul_res),
    .ovf (mul_ovf)
  );

  fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .en  (en),
    .a   (s1_r.operand_a),
    .b   (s1_r.operand_b),
    .res (div_res),
    .dbz (div_dbz),
    .ovf (div_ovf)
  );

  // Valid bits of the alignment line.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        side_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      side_v_r[0] <= s1_valid_r;
      for (int k = 1; k < LAT; k++) begin
        side_v_r[k] <= side_v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0]  <= side_nxt;
      for (int k = 1; k < LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
      mline_r[0] <= '{res: mul_res, ovf: mul_ovf};
      for (int k = 1; k < MD; k++) begin
        mline_r[k] <= mline_r[k-1];
      end
    end
  end

  // Pick the unit that owns the beat's mode.
  always_comb begin
    out_nxt.a_equals_b     = side_r[LAT-1].eq;
    out_nxt.a_less_than_b  = side_r[LAT-1].lt;
    out_nxt.divide_by_zero = 1'b0;
    case (side_r[LAT-1].mode)
      MODE_MUL: begin
        out_nxt.result_value = mline_r[MD-1].res;
        out_nxt.overflowed   = mline_r[MD-1].ovf;
      end
      MODE_DIV: begin
        out_nxt.result_value   = div_res;
        out_nxt.overflowed     = div_ovf;
        out_nxt.divide_by_zero = div_dbz;
      end
      default: begin
        out_nxt.result_value = side_r[LAT-1].res;
        out_nxt.overflowed   = side_r[LAT-1].ovf;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side_v_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/fpa_chk.sv =====
// Port-level checker for the fixed-point ALU, bound to the top level.
`include "fixed_point_alu_assert.svh"

module fpa_chk
  import fpa_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `FPA_AST_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `FPA_AST_IMP(a_rdy_flow, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready))
  `FPA_AST_IMP(a_dbz_zero, clk, rst_n, out_valid && out_data.divide_by_zero, out_data.result_value == '0 && !out_data.overflowed)
  `FPA_AST_IMP(a_cmp_excl, clk, rst_n, out_valid && out_data.a_equals_b, !out_data.a_less_than_b)

endmodule

bind fixed_point_alu fpa_chk u_fpa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
